// File: rtl/core/mrrs_pkg.sv
// ----------------------------------------------------------------------------
// mrrs_pkg
// Shared types and codes for the multicore round-robin scheduler.
// ----------------------------------------------------------------------------
package mrrs_pkg;

	localparam int TASK_W   = 8;
	localparam int CORE_W   = 2;
	localparam int OP_W     = 3;
	localparam int QUANT_W  = 16;
	localparam int ACTIVE_W = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [QUANT_W-1:0] COUNTER_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_TICK    = 3'd0,
		OP_BLOCK   = 3'd1,
		OP_EXIT    = 3'd2,
		OP_LOAD    = 3'd3,
		OP_UNBLOCK = 3'd4
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CORES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0     = 3'd1;

	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [CORE_W-1:0] core;
		logic [TASK_W-1:0] task_id;
	} item_t;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [TASK_W-1:0] data;
	} q_ctrl_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [TASK_W-1:0] head;
	} q_stat_t;

	typedef struct packed {
		logic [TASK_W-1:0] run_task;
		logic              run_idle;
		logic              accepted;
	} result_t;

endpackage

// File: rtl/core/mrrs_queue.sv
// ----------------------------------------------------------------------------
// mrrs_queue
// Shared FIFO ready queue with the head entry held in a register.
// ----------------------------------------------------------------------------
module mrrs_queue import mrrs_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  q_ctrl_t ctrl,
	output q_stat_t stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [TASK_W-1:0] mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [TASK_W-1:0] head_data_q;

	logic [PTR_W-1:0]  head_inc, tail_inc, head_nx, tail_nx;
	logic [CNT_W-1:0]  count_nx;

	assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign head_nx  = ctrl.pop  ? head_inc : head_q;
	assign tail_nx  = ctrl.push ? tail_inc : tail_q;

	always_comb begin
		case ({ctrl.push, ctrl.pop})
			2'b10:   count_nx = count_q + 1'b1;
			2'b01:   count_nx = count_q - 1'b1;
			default: count_nx = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_nx;
			tail_q  <= tail_nx;
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= ctrl.data;
		end
	end

	// head entry prefetch, bypassing a write to the new head slot
	always_ff @(posedge clk) begin
		if (ctrl.push && (tail_q == head_nx)) begin
			head_data_q <= ctrl.data;
		end else begin
			head_data_q <= mem[head_nx];
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.head  = head_data_q;

endmodule

// File: rtl/core/mrrs_cores.sv
// ----------------------------------------------------------------------------
// mrrs_cores
// Per-core state, configuration registers and event handling.
// ----------------------------------------------------------------------------
module mrrs_cores import mrrs_pkg::*; #(
	parameter int NUM_CORES = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  item_t                 item,
	input  q_stat_t               q_stat,
	output q_ctrl_t               q_ctrl,
	output result_t               res
);

	logic [QUANT_W-1:0]  counter_q [NUM_CORES];
	logic [TASK_W-1:0]   task_q    [NUM_CORES];
	logic                idle_q    [NUM_CORES];
	logic [QUANT_W-1:0]  quantum_q [NUM_CORES];
	logic [ACTIVE_W-1:0] active_q;

	logic [QUANT_W-1:0] sel_cnt, sel_quant, cnt_inc, new_cnt;
	logic [TASK_W-1:0]  sel_task, new_task;
	logic               sel_idle, new_idle, in_range, active, upd;
	logic               acc;

	always_comb begin
		sel_cnt   = '0;
		sel_quant = '0;
		sel_task  = '0;
		sel_idle  = 1'b1;
		in_range  = 1'b0;
		for (int i = 0; i < NUM_CORES; i++) begin
			if (item.core == CORE_W'(i)) begin
				sel_cnt   = counter_q[i];
				sel_quant = quantum_q[i];
				sel_task  = task_q[i];
				sel_idle  = idle_q[i];
				in_range  = 1'b1;
			end
		end
	end

	assign active  = in_range && ({1'b0, item.core} < active_q);
	assign cnt_inc = (sel_cnt == COUNTER_MAX) ? sel_cnt : sel_cnt + 1'b1;

	always_comb begin
		new_cnt      = sel_cnt;
		new_task     = sel_task;
		new_idle     = sel_idle;
		upd          = 1'b0;
		q_ctrl.push  = 1'b0;
		q_ctrl.pop   = 1'b0;
		q_ctrl.data  = item.task_id;
		acc          = 1'b1;
		if (item.valid) begin
			case (item.op)
				OP_LOAD, OP_UNBLOCK: begin
					acc         = !q_stat.full;
					q_ctrl.push = !q_stat.full;
				end
				OP_TICK: begin
					upd     = active;
					new_cnt = cnt_inc;
					if (sel_idle) begin
						if (!q_stat.empty) begin
							q_ctrl.pop = active;
							new_cnt    = '0;
							new_task   = q_stat.head;
							new_idle   = 1'b0;
						end
					end else if (cnt_inc >= sel_quant) begin
						// slice expired: rotate through the queue
						new_cnt = '0;
						if (!q_stat.empty) begin
							q_ctrl.pop  = active;
							q_ctrl.push = active;
							q_ctrl.data = sel_task;
							new_task    = q_stat.head;
						end
					end
				end
				OP_BLOCK, OP_EXIT: begin
					upd     = active;
					new_cnt = '0;
					if (!q_stat.empty) begin
						q_ctrl.pop = active;
						new_task   = q_stat.head;
						new_idle   = 1'b0;
					end else begin
						new_task = '0;
						new_idle = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (!upd) begin
			new_cnt  = sel_cnt;
			new_task = sel_task;
			new_idle = sel_idle;
		end
	end

	assign res.run_task = new_idle ? '0 : new_task;
	assign res.run_idle = new_idle;
	assign res.accepted = acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CORES; i++) begin
				counter_q[i] <= '0;
				task_q[i]    <= '0;
				idle_q[i]    <= 1'b1;
			end
		end else if (upd) begin
			for (int i = 0; i < NUM_CORES; i++) begin
				if (item.core == CORE_W'(i)) begin
					counter_q[i] <= new_cnt;
					task_q[i]    <= new_task;
					idle_q[i]    <= new_idle;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_W'(1);
			for (int i = 0; i < NUM_CORES; i++) begin
				quantum_q[i] <= QUANT_W'(1);
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_ACTIVE_CORES) begin
				active_q <= cfg_data[ACTIVE_W-1:0];
			end
			for (int i = 0; i < NUM_CORES; i++) begin
				if (cfg_index == CFG_IDX_W'(CFG_QUANTUM0 + i)) begin
					quantum_q[i] <= cfg_data[QUANT_W-1:0];
				end
			end
		end
	end

endmodule

// File: rtl/core/multicore_round_robin_scheduler_top.sv
// ----------------------------------------------------------------------------
// multicore_round_robin_scheduler_top
// Round-robin scheduler for several cores sharing one FIFO ready queue.
// ----------------------------------------------------------------------------
// One event is taken per clock cycle; busy is always low. An event taken at
// one edge is registered, handled in the following cycle against the queue
// and core state, and its result is registered onto the outputs with done
// high for exactly one cycle. The receiver cannot stall: each result is
// presented once and must be captured in that cycle. The queue head is held
// in a register reloaded from the queue memory every cycle, with a bypass
// for a write into the new head slot, so no clearing pass is needed after
// reset.
module multicore_round_robin_scheduler_top import mrrs_pkg::*; #(
	parameter int NUM_CORES   = 4,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [OP_W-1:0]       opcode,
	input  logic [CORE_W-1:0]     core,
	input  logic [TASK_W-1:0]     task_id,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [TASK_W-1:0]     run_task,
	output logic                  run_idle,
	output logic                  accepted
);

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [CORE_W-1:0] core_s1;
	logic [TASK_W-1:0] tid_s1;

	item_t   item;
	q_ctrl_t q_ctrl;
	q_stat_t q_stat;
	result_t res;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= opcode;
		core_s1 <= core;
		tid_s1  <= task_id;
	end

	assign item.valid   = valid_s1;
	assign item.op      = op_t'(op_s1);
	assign item.core    = core_s1;
	assign item.task_id = tid_s1;

	mrrs_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (q_ctrl),
		.stat  (q_stat)
	);

	mrrs_cores #(
		.NUM_CORES(NUM_CORES)
	) u_cores (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item),
		.q_stat   (q_stat),
		.q_ctrl   (q_ctrl),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		run_task <= res.run_task;
		run_idle <= res.run_idle;
		accepted <= res.accepted;
	end

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("registered event gave no result");

	a_idle_task_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && run_idle) |-> (run_task == '0))
		else $error("idle core reports a task");

	a_drop_only_enqueue: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !res.accepted) |-> (item.op == OP_LOAD || item.op == OP_UNBLOCK))
		else $error("non-enqueue event flagged as dropped");

	a_rotate_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		(q_ctrl.pop && q_ctrl.push) |-> !q_stat.empty)
		else $error("rotation on an empty queue");

endmodule
